// File: hw/rtl/sc1a_pkg.sv
package sc1a_pkg;

  localparam logic [7:0] CodeExt   = 8'hE0;
  localparam logic [6:0] KeyCtrl   = 7'h1D;
  localparam logic [6:0] KeyLShift = 7'h2A;
  localparam logic [6:0] KeyRShift = 7'h36;
  localparam logic [6:0] KeyCaps   = 7'h3A;
  localparam logic [6:0] CaseBit   = 7'h20;
  localparam logic [6:0] CtrlMask  = 7'h1F;

  typedef struct packed {
    logic       emit;
    logic [6:0] code;
  } xlate_res_t;

  function automatic logic is_letter(input logic [6:0] ch);
    return ((ch >= 7'h61) && (ch <= 7'h7A)) || ((ch >= 7'h41) && (ch <= 7'h5A));
  endfunction

  function automatic logic [6:0] plain_char(input logic [6:0] key);
    logic [6:0] ch;
    unique case (key)
      7'h01: ch = 7'h1B;
      7'h02: ch = 7'h31;
      7'h03: ch = 7'h32;
      7'h04: ch = 7'h33;
      7'h05: ch = 7'h34;
      7'h06: ch = 7'h35;
      7'h07: ch = 7'h36;
      7'h08: ch = 7'h37;
      7'h09: ch = 7'h38;
      7'h0A: ch = 7'h39;
      7'h0B: ch = 7'h30;
      7'h0C: ch = 7'h2D;
      7'h0D: ch = 7'h3D;
      7'h0E: ch = 7'h08;
      7'h0F: ch = 7'h09;
      7'h10: ch = 7'h71;
      7'h11: ch = 7'h77;
      7'h12: ch = 7'h65;
      7'h13: ch = 7'h72;
      7'h14: ch = 7'h74;
      7'h15: ch = 7'h79;
      7'h16: ch = 7'h75;
      7'h17: ch = 7'h69;
      7'h18: ch = 7'h6F;
      7'h19: ch = 7'h70;
      7'h1A: ch = 7'h5B;
      7'h1B: ch = 7'h5D;
      7'h1C: ch = 7'h0A;
      7'h1E: ch = 7'h61;
      7'h1F: ch = 7'h73;
      7'h20: ch = 7'h64;
      7'h21: ch = 7'h66;
      7'h22: ch = 7'h67;
      7'h23: ch = 7'h68;
      7'h24: ch = 7'h6A;
      7'h25: ch = 7'h6B;
      7'h26: ch = 7'h6C;
      7'h27: ch = 7'h3B;
      7'h28: ch = 7'h27;
      7'h29: ch = 7'h60;
      7'h2B: ch = 7'h5C;
      7'h2C: ch = 7'h7A;
      7'h2D: ch = 7'h78;
      7'h2E: ch = 7'h63;
      7'h2F: ch = 7'h76;
      7'h30: ch = 7'h62;
      7'h31: ch = 7'h6E;
      7'h32: ch = 7'h6D;
      7'h33: ch = 7'h2C;
      7'h34: ch = 7'h2E;
      7'h35: ch = 7'h2F;
      7'h37: ch = 7'h2A;
      7'h39: ch = 7'h20;
      7'h4A: ch = 7'h2D;
      7'h4E: ch = 7'h2B;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [6:0] shift_char(input logic [6:0] key);
    logic [6:0] base;
    logic [6:0] ch;
    base = plain_char(key);
    unique case (key)
      7'h02: ch = 7'h21;
      7'h03: ch = 7'h40;
      7'h04: ch = 7'h23;
      7'h05: ch = 7'h24;
      7'h06: ch = 7'h25;
      7'h07: ch = 7'h5E;
      7'h08: ch = 7'h26;
      7'h09: ch = 7'h2A;
      7'h0A: ch = 7'h28;
      7'h0B: ch = 7'h29;
      7'h0C: ch = 7'h5F;
      7'h0D: ch = 7'h2B;
      7'h1A: ch = 7'h7B;
      7'h1B: ch = 7'h7D;
      7'h27: ch = 7'h3A;
      7'h28: ch = 7'h22;
      7'h29: ch = 7'h7E;
      7'h2B: ch = 7'h7C;
      7'h33: ch = 7'h3C;
      7'h34: ch = 7'h3E;
      7'h35: ch = 7'h3F;
      default: ch = is_letter(base) ? (base ^ CaseBit) : base;
    endcase
    return ch;
  endfunction

endpackage

// File: hw/rtl/sc1a_scan_if.sv
interface sc1a_scan_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;
  logic       from_aux;

  modport source (output valid, output scan_byte, output from_aux, input ready);
  modport sink   (input valid, input scan_byte, input from_aux, output ready);
endinterface

// File: hw/rtl/sc1a_char_if.sv
interface sc1a_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

// File: hw/rtl/scancode_set1_to_ascii_unit.sv
// Set-1 keyboard scancode to ASCII translator (US layout).
// Input channel scan_i carries one controller byte per transfer plus a flag
// that marks bytes from the auxiliary port; those are dropped without effect.
// Output channel char_o carries one 7-bit character per transfer, never zero.
// Modifier bytes and extended codes update the shift, ctrl, caps-lock and
// prefix flags; these, releases and keys without a character produce nothing.
// An accepted item is captured in the input register, and its character is
// then loaded into the result register that drives char_o.valid.
// Throughput: one item per cycle while the receiver does not stall; the table
// lookup and flag update are a single pass of logic between the input and result registers.
// When the receiver stalls, the result register holds its character and the
// input register keeps the next byte; scan_i.ready falls only when an item
// that produces a character waits behind a held result.
// Reset clears all key flags and empties both registers.
module scancode_set1_to_ascii_unit
  import sc1a_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  sc1a_scan_if.sink   scan_i,
  sc1a_char_if.source char_o
);

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q, in_byte_d;
  logic       in_aux_q, in_aux_d;
  logic       out_valid_q, out_valid_d;
  logic [6:0] out_code_q, out_code_d;
  logic       advance;
  logic       in_take;
  xlate_res_t res;

  sc1a_xlate u_xlate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .scan_byte_i (in_byte_q),
    .from_aux_i  (in_aux_q),
    .res_o       (res)
  );

  assign advance      = in_valid_q && (!res.emit || !out_valid_q || char_o.ready);
  assign scan_i.ready = !in_valid_q || advance;
  assign in_take      = scan_i.valid && scan_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    in_byte_d  = in_byte_q;
    in_aux_d   = in_aux_q;
    if (in_take) begin
      in_valid_d = 1'b1;
      in_byte_d  = scan_i.scan_byte;
      in_aux_d   = scan_i.from_aux;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_code_d  = out_code_q;
    if (advance && res.emit) begin
      out_valid_d = 1'b1;
      out_code_d  = res.code;
    end else if (char_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q  <= in_byte_d;
    in_aux_q   <= in_aux_d;
    out_code_q <= out_code_d;
  end

  assign char_o.valid     = out_valid_q;
  assign char_o.char_code = out_code_q;

`ifndef NO_ASSERTIONS
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res.emit) |=> (out_valid_q && (out_code_q == $past(res.code))))
    else $error("translated character not loaded into result register");

  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_byte_q) && $stable(in_aux_q)))
    else $error("stalled input register lost its byte");

  a_take_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_valid_q)
    else $error("accepted byte not captured");
`endif

endmodule

// File: hw/rtl/sc1a_xlate.sv
module sc1a_xlate
  import sc1a_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  logic [7:0] scan_byte_i,
  input  logic       from_aux_i,
  output xlate_res_t res_o
);

  logic       shift_q, shift_d;
  logic       ctrl_q, ctrl_d;
  logic       caps_q, caps_d;
  logic       ext_q, ext_d;
  logic [6:0] key;
  logic       rel;
  logic       is_ext;
  logic       is_mod;
  logic [6:0] lookup;
  logic [6:0] cased;

  assign key    = scan_byte_i[6:0];
  assign rel    = scan_byte_i[7];
  assign is_ext = (scan_byte_i == CodeExt);
  assign is_mod = (key == KeyLShift) || (key == KeyRShift) || (key == KeyCtrl) ||
                  (key == KeyCaps);

  always_comb begin
    shift_d = shift_q;
    ctrl_d  = ctrl_q;
    caps_d  = caps_q;
    ext_d   = ext_q;
    if (advance_i && !from_aux_i) begin
      if (is_ext) begin
        ext_d = 1'b1;
      end else if (ext_q) begin
        ext_d = 1'b0;
        if (key == KeyCtrl) begin
          ctrl_d = !rel;
        end
      end else if ((key == KeyLShift) || (key == KeyRShift)) begin
        shift_d = !rel;
      end else if (key == KeyCtrl) begin
        ctrl_d = !rel;
      end else if ((key == KeyCaps) && !rel) begin
        caps_d = !caps_q;
      end
    end
  end

  always_comb begin
    lookup = shift_q ? shift_char(key) : plain_char(key);
    cased  = (caps_q && is_letter(lookup)) ? (lookup ^ CaseBit) : lookup;
    res_o.code = (ctrl_q && is_letter(cased)) ? (cased & CtrlMask) : cased;
    res_o.emit = !from_aux_i && !is_ext && !ext_q && !is_mod && !rel &&
                 (lookup != 7'h00);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 1'b0;
      ctrl_q  <= 1'b0;
      caps_q  <= 1'b0;
      ext_q   <= 1'b0;
    end else begin
      shift_q <= shift_d;
      ctrl_q  <= ctrl_d;
      caps_q  <= caps_d;
      ext_q   <= ext_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_emit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.emit |-> (res_o.code != 7'h00))
    else $error("emitted character is zero");

  a_aux_keeps_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && from_aux_i) |=> ($stable(shift_q) && $stable(ctrl_q) &&
                                   $stable(caps_q) && $stable(ext_q)))
    else $error("auxiliary byte changed key state");

  a_prefix_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && !from_aux_i && is_ext) |=> ext_q)
    else $error("prefix byte did not set pending flag");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import sc1a_pkg::*;

  localparam int         CycleLimit = 400000;
  localparam logic [7:0] RelBit     = 8'h80;

  logic clk = 1'b0;
  logic rst_n;

  sc1a_scan_if scan_if ();
  sc1a_char_if char_if ();

  scancode_set1_to_ascii_unit u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .scan_i (scan_if),
    .char_o (char_if)
  );

  bit shift_q;
  bit ctrl_q;
  bit caps_q;
  bit ext_q;

  logic [6:0] char_exp_q[$];

  bit send_idle;
  bit take_idle;
  int n_keyb;
  int n_aux;
  int n_chars;
  int n_err;
  int cycles;

  initial forever #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  // high byte: unshifted glyph, low byte: shifted glyph
  function automatic logic [15:0] key_glyphs(input logic [6:0] key);
    case (key)
      7'h01: return {8'd27, 8'd27};
      7'h02: return "1!";  7'h03: return "2@";  7'h04: return "3#";  7'h05: return "4$";
      7'h06: return "5%";  7'h07: return "6^";  7'h08: return "7&";  7'h09: return "8*";
      7'h0A: return "9(";  7'h0B: return "0)";  7'h0C: return "-_";  7'h0D: return "=+";
      7'h0E: return {8'd8, 8'd8};
      7'h0F: return {8'd9, 8'd9};
      7'h10: return "qQ";  7'h11: return "wW";  7'h12: return "eE";  7'h13: return "rR";
      7'h14: return "tT";  7'h15: return "yY";  7'h16: return "uU";  7'h17: return "iI";
      7'h18: return "oO";  7'h19: return "pP";  7'h1A: return "[{";  7'h1B: return "]}";
      7'h1C: return {8'd10, 8'd10};
      7'h1E: return "aA";  7'h1F: return "sS";  7'h20: return "dD";  7'h21: return "fF";
      7'h22: return "gG";  7'h23: return "hH";  7'h24: return "jJ";  7'h25: return "kK";
      7'h26: return "lL";  7'h27: return ";:";  7'h28: return "'\"";  7'h29: return "`~";
      7'h2B: return "\\|";
      7'h2C: return "zZ";  7'h2D: return "xX";  7'h2E: return "cC";  7'h2F: return "vV";
      7'h30: return "bB";  7'h31: return "nN";  7'h32: return "mM";  7'h33: return ",<";
      7'h34: return ".>";  7'h35: return "/?";  7'h37: return "**";  7'h39: return "  ";
      7'h4A: return "--";  7'h4E: return "++";
      default: return 16'h0000;
    endcase
  endfunction

  function automatic bit alpha(input logic [6:0] c);
    return (c | CaseBit) inside {[7'h61:7'h7A]};
  endfunction

  task automatic predict_char(input logic [7:0] b, input logic aux);
    logic [6:0]  key;
    logic        rel;
    logic [15:0] glyphs;
    logic [6:0]  ch;
    key = b[6:0];
    rel = b[7];
    if (aux) return;
    if (b == CodeExt) begin
      ext_q = 1'b1;
      return;
    end
    if (ext_q) begin
      ext_q = 1'b0;
      if (key == KeyCtrl) ctrl_q = !rel;
      return;
    end
    if (key == KeyLShift || key == KeyRShift) begin
      shift_q = !rel;
      return;
    end
    if (key == KeyCtrl) begin
      ctrl_q = !rel;
      return;
    end
    if (key == KeyCaps) begin
      if (!rel) caps_q = !caps_q;
      return;
    end
    if (rel) return;
    glyphs = key_glyphs(key);
    ch = shift_q ? glyphs[6:0] : glyphs[14:8];
    if (ch == 7'h00) return;
    if (caps_q && alpha(ch)) ch = ch ^ CaseBit;
    if (ctrl_q && alpha(ch)) ch = ch & CtrlMask;
    char_exp_q.push_back(ch);
  endtask

  function automatic int draw_gap(input bit on);
    if (!on) return 0;
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 16);
  endfunction

  task automatic send_scan(input logic [7:0] b, input logic aux);
    int gap;
    bit acc;
    gap = draw_gap(send_idle);
    if (gap != 0) begin
      scan_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    scan_if.valid     <= 1'b1;
    scan_if.scan_byte <= b;
    scan_if.from_aux  <= aux;
    do begin
      @(negedge clk);
      acc = scan_if.ready;
      @(posedge clk);
    end while (!acc);
    predict_char(b, aux);
    if (aux) n_aux++;
    else n_keyb++;
  endtask

  task automatic settle_out();
    scan_if.valid <= 1'b0;
    while (char_exp_q.size() != 0) @(posedge clk);
  endtask

  initial begin : char_check
    int  stall;
    bit  seen;
    logic [6:0] want;
    char_if.ready <= 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      stall = draw_gap(take_idle);
      if (stall != 0) begin
        char_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      char_if.ready <= 1'b1;
      do begin
        @(negedge clk);
        seen = char_if.valid;
        if (seen) begin
          n_chars++;
          if (char_exp_q.size() == 0) begin
            $error("char_code: expected none, actual %h", char_if.char_code);
            n_err++;
          end else begin
            want = char_exp_q.pop_front();
            if (char_if.char_code !== want) begin
              $error("char_code: expected %h, actual %h", want, char_if.char_code);
              n_err++;
            end
          end
        end
        @(posedge clk);
      end while (!seen);
    end
  end

  task automatic test_directed();
    send_scan(8'h00, 1'b0);
    send_scan(8'hFF, 1'b0);
    send_scan(8'h1E, 1'b1);
    send_scan(CodeExt, 1'b1);
    send_scan(8'h1E, 1'b0);
    send_scan({1'b0, KeyRShift}, 1'b0);
    send_scan(8'h02, 1'b0);
    send_scan({1'b1, KeyLShift}, 1'b0);
    send_scan(8'h1E, 1'b0);
    send_scan({1'b0, KeyCaps}, 1'b0);
    send_scan({1'b1, KeyCaps}, 1'b0);
    send_scan(8'h2C, 1'b0);
    send_scan({1'b0, KeyLShift}, 1'b0);
    send_scan(8'h2C, 1'b0);
    send_scan({1'b0, KeyCtrl}, 1'b0);
    send_scan(8'h1C, 1'b0);
    send_scan(8'h2C, 1'b0);
    send_scan({1'b1, KeyCtrl}, 1'b0);
    send_scan(CodeExt, 1'b0);
    send_scan({1'b0, KeyCtrl}, 1'b0);
    send_scan(8'h10, 1'b0);
    send_scan(CodeExt, 1'b0);
    send_scan({1'b1, KeyCtrl}, 1'b0);
    send_scan(CodeExt, 1'b0);
    send_scan(CodeExt, 1'b0);
    send_scan(8'h1E, 1'b0);
    send_scan({1'b0, KeyCaps}, 1'b0);
    send_scan({1'b1, KeyRShift}, 1'b0);
    send_scan(8'h9E, 1'b0);
    send_scan(8'h4E, 1'b0);
  endtask

  // press/release sequences with modifiers, prefixes and some noise
  task automatic type_keys(input int count);
    int         stop;
    int         sel;
    bit         r;
    bit         r2;
    logic [6:0] k;
    logic [7:0] b;
    stop = n_keyb + count;
    while (n_keyb < stop) begin
      sel = $urandom_range(0, 99);
      r   = 1'($urandom_range(0, 1));
      r2  = 1'($urandom_range(0, 1));
      k   = 7'($urandom_range(1, 7'h39));
      b   = 8'($urandom_range(0, 255));
      if (sel < 45) begin
        send_scan({1'b0, k}, 1'b0);
        if ($urandom_range(0, 3) != 0) send_scan({1'b1, k}, 1'b0);
      end else if (sel < 55) begin
        send_scan({r2, r ? KeyLShift : KeyRShift}, 1'b0);
      end else if (sel < 62) begin
        if (r) send_scan(CodeExt, 1'b0);
        send_scan({r2, KeyCtrl}, 1'b0);
      end else if (sel < 67) begin
        send_scan({1'b0, KeyCaps}, 1'b0);
        if (r) send_scan({1'b1, KeyCaps}, 1'b0);
      end else if (sel < 77) begin
        send_scan(CodeExt, 1'b0);
        send_scan(b, 1'b0);
      end else if (sel < 87) begin
        send_scan(b, 1'b1);
      end else begin
        send_scan(b | (r ? RelBit : 8'h00), 1'b0);
      end
    end
  endtask

  task automatic spray_bytes(input int count);
    int         stop;
    logic [7:0] b;
    stop = n_keyb + count;
    while (n_keyb < stop) begin
      b = ($urandom_range(0, 9) == 0) ? CodeExt : 8'($urandom_range(0, 255));
      send_scan(b, $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic test_typing();
    send_idle = 1'b1;
    take_idle = 1'b1;
    type_keys(700);
  endtask

  task automatic test_full_rate();
    send_idle = 1'b0;
    take_idle = 1'b0;
    type_keys(200);
  endtask

  task automatic test_slow_reader();
    send_idle = 1'b0;
    take_idle = 1'b1;
    type_keys(150);
  endtask

  task automatic test_drain_pause();
    settle_out();
    send_idle = 1'b0;
    take_idle = 1'b0;
    type_keys(100);
  endtask

  task automatic test_raw_noise();
    send_idle = 1'b1;
    take_idle = 1'b1;
    spray_bytes(250);
  endtask

  initial begin
    scan_if.valid     <= 1'b0;
    scan_if.scan_byte <= 8'h00;
    scan_if.from_aux  <= 1'b0;
    rst_n             <= 1'b0;
    send_idle = 1'b1;
    take_idle = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_typing();
    test_full_rate();
    test_slow_reader();
    test_drain_pause();
    test_raw_noise();

    settle_out();
    repeat (10) @(posedge clk);
    $display("covered %0d keyboard bytes and %0d aux-port bytes, %0d characters checked",
             n_keyb, n_aux, n_chars);
    if (n_err == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
